[hw/rtl/bfw_pkg.sv]
package bfw_pkg;

   // Framebuffer geometry and header layout.
   localparam int LINE_PIXELS   = 640;
   localparam int HEADER_BYTES  = 54;
   localparam int MAX_DIM       = 2047;
   localparam int INFO_OFFSET   = 14;
   localparam int WIDTH_OFFSET  = INFO_OFFSET + 4;
   localparam int HEIGHT_OFFSET = INFO_OFFSET + 8;

   // Field and counter widths.
   localparam int BYTE_W   = 8;
   localparam int DIM_W    = 12;
   localparam int COORD_W  = 11;
   localparam int ADDR_W   = 22;
   localparam int PIXEL_W  = 24;
   localparam int RAW_W    = 32;
   localparam int HCOUNT_W = 6;

   // Queue between the byte parser and the address stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register indexes of the configuration port.
   localparam logic [0:0] CSR_ORIGIN_ROW = 1'b0;
   localparam logic [0:0] CSR_ORIGIN_COL = 1'b1;

   // Position inside one blue, green, red triple.
   typedef enum logic [1:0] {
      PHASE_BLUE,
      PHASE_GREEN,
      PHASE_RED
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] file_byte;
      logic              first;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  fb_address;
      logic [PIXEL_W-1:0] pixel;
      logic               last_pixel;
   } rsp_type;

   // One pixel write as handed from the parser to the address stage.
   typedef struct packed {
      logic [DIM_W-1:0]   row;
      logic [DIM_W-1:0]   col;
      logic [PIXEL_W-1:0] pixel;
      logic               last_pixel;
   } job_type;

   // Queue status seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Negative dimensions count as zero, large ones saturate.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [RAW_W-1:0] raw);
      logic [DIM_W-1:0] result;
      if (raw[RAW_W-1]) begin
         result = '0;
      end else if (raw > RAW_W'(MAX_DIM)) begin
         result = DIM_W'(MAX_DIM);
      end else begin
         result = raw[DIM_W-1:0];
      end
      return result;
   endfunction

endpackage

[hw/rtl/bfw_front.sv]
module bfw_front
   import bfw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  req_type            req_data,
   input  logic [COORD_W-1:0] origin_row,
   input  logic [COORD_W-1:0] origin_col,
   output logic               push,
   output job_type            push_data
);

   logic [HCOUNT_W-1:0] header_count_ff, header_count_in;
   logic [RAW_W-1:0]    raw_width_ff, raw_width_in;
   logic [RAW_W-1:0]    raw_height_ff, raw_height_in;
   logic [DIM_W-1:0]    img_width_ff, img_width_in;
   logic [DIM_W-1:0]    img_height_ff, img_height_in;
   logic [DIM_W-1:0]    column_count_ff, column_count_in;
   logic [DIM_W-1:0]    file_row_ff, file_row_in;
   phase_type           byte_phase_ff, byte_phase_in;
   logic [1:0]          pad_left_ff, pad_left_in;
   logic [BYTE_W-1:0]   blue_hold_ff, blue_hold_in;
   logic [BYTE_W-1:0]   green_hold_ff, green_hold_in;
   logic                in_pixels_ff, in_pixels_in;
   logic                emit;

   // Parse one byte: header fields first, then pixel triples and row padding.
   always_comb begin
      logic [HCOUNT_W-1:0] hc;
      logic [RAW_W-1:0]    rw;
      logic [RAW_W-1:0]    rh;
      logic [DIM_W-1:0]    w;
      logic [DIM_W-1:0]    h;
      logic [DIM_W-1:0]    cc;
      logic [DIM_W-1:0]    fr;
      phase_type           ph;
      logic [1:0]          pad;
      logic [BYTE_W-1:0]   bh;
      logic [BYTE_W-1:0]   gh;
      logic                inp;
      logic [1:0]          sel;
      logic [BYTE_W-1:0]   b;
      logic [DIM_W-1:0]    cc_next;

      b = req_data.file_byte;

      // A first-marked byte sees the state of a freshly started file.
      if (req_data.first) begin
         hc = '0; rw = '0; rh = '0; w = '0; h = '0; cc = '0; fr = '0;
         ph = PHASE_BLUE; pad = '0; bh = '0; gh = '0; inp = 1'b0;
      end else begin
         hc = header_count_ff; rw = raw_width_ff; rh = raw_height_ff;
         w = img_width_ff; h = img_height_ff; cc = column_count_ff;
         fr = file_row_ff; ph = byte_phase_ff; pad = pad_left_ff;
         bh = blue_hold_ff; gh = green_hold_ff; inp = in_pixels_ff;
      end

      header_count_in = hc;
      raw_width_in    = rw;
      raw_height_in   = rh;
      img_width_in    = w;
      img_height_in   = h;
      column_count_in = cc;
      file_row_in     = fr;
      byte_phase_in   = ph;
      pad_left_in     = pad;
      blue_hold_in    = bh;
      green_hold_in   = gh;
      in_pixels_in    = inp;
      emit            = 1'b0;
      sel             = '0;
      cc_next         = cc + 1'b1;

      push_data.row        = DIM_W'(origin_row) + h - 1'b1 - fr;
      push_data.col        = DIM_W'(origin_col) + cc;
      push_data.pixel      = {bh, gh, b};
      push_data.last_pixel = (cc_next == w) && ((fr + 1'b1) == h);

      if (!inp) begin
         // Header: collect the little-endian width and height.
         if (hc >= HCOUNT_W'(WIDTH_OFFSET) && hc < HCOUNT_W'(WIDTH_OFFSET + 4)) begin
            sel = 2'(hc - HCOUNT_W'(WIDTH_OFFSET));
            raw_width_in[BYTE_W*sel +: BYTE_W] = rw[BYTE_W*sel +: BYTE_W] | b;
         end else if (hc >= HCOUNT_W'(HEIGHT_OFFSET)
                      && hc < HCOUNT_W'(HEIGHT_OFFSET + 4)) begin
            sel = 2'(hc - HCOUNT_W'(HEIGHT_OFFSET));
            raw_height_in[BYTE_W*sel +: BYTE_W] = rh[BYTE_W*sel +: BYTE_W] | b;
         end
         header_count_in = hc + 1'b1;
         if (header_count_in >= HCOUNT_W'(HEADER_BYTES)) begin
            in_pixels_in  = 1'b1;
            img_width_in  = clamp_dim(raw_width_in);
            img_height_in = clamp_dim(raw_height_in);
         end
      end else if (w == '0 || fr >= h) begin
         // Empty image or bytes past the last row: ignored.
      end else if (pad != '0) begin
         pad_left_in = pad - 1'b1;
      end else if (ph == PHASE_BLUE) begin
         blue_hold_in  = b;
         byte_phase_in = PHASE_GREEN;
      end else if (ph == PHASE_GREEN) begin
         green_hold_in = b;
         byte_phase_in = PHASE_RED;
      end else begin
         // Red byte completes a pixel; wrap the row and set its padding.
         emit          = 1'b1;
         byte_phase_in = PHASE_BLUE;
         if (cc_next >= w) begin
            column_count_in = '0;
            file_row_in     = fr + 1'b1;
            pad_left_in     = 2'(2'b00 - 2'(2'd3 * w[1:0]));
         end else begin
            column_count_in = cc_next;
         end
      end
   end

   assign push = take && emit;

   // Parser state advances on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= '0;
         raw_width_ff    <= '0;
         raw_height_ff   <= '0;
         img_width_ff    <= '0;
         img_height_ff   <= '0;
         column_count_ff <= '0;
         file_row_ff     <= '0;
         byte_phase_ff   <= PHASE_BLUE;
         pad_left_ff     <= '0;
         in_pixels_ff    <= 1'b0;
      end else if (take) begin
         header_count_ff <= header_count_in;
         raw_width_ff    <= raw_width_in;
         raw_height_ff   <= raw_height_in;
         img_width_ff    <= img_width_in;
         img_height_ff   <= img_height_in;
         column_count_ff <= column_count_in;
         file_row_ff     <= file_row_in;
         byte_phase_ff   <= byte_phase_in;
         pad_left_ff     <= pad_left_in;
         in_pixels_ff    <= in_pixels_in;
      end
   end

   // Color holds are payload and are always written before use.
   always_ff @(posedge clock) begin
      if (take) begin
         blue_hold_ff  <= blue_hold_in;
         green_hold_ff <= green_hold_in;
      end
   end

endmodule

[hw/rtl/bfw_queue.sv]
module bfw_queue
   import bfw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_data,
   input  logic             pop,
   output job_type          pop_data,
   output queue_status_type status
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[hw/rtl/bfw_back.sv]
module bfw_back
   import bfw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type status,
   input  job_type          job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   // Take a job whenever the output register is empty or being drained.
   assign pop = !status.empty && (!out_valid_ff || rsp_ready);

   // Framebuffer word index: row times line width plus column.
   always_comb begin
      out_data_in.fb_address = ADDR_W'(job.row) * ADDR_W'(LINE_PIXELS) + ADDR_W'(job.col);
      out_data_in.pixel      = job.pixel;
      out_data_in.last_pixel = job.last_pixel;
      out_valid_in           = pop || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[hw/rtl/bmp_to_framebuffer_writer_unit.sv]
// Streams a 24-bit bottom-up BMP file, one byte per item, into framebuffer
// writes. The width and height are taken from the header, then every
// blue, green, red byte triple yields one result item with its word address
// (row times 640 plus column) and the packed pixel; the image's top row lands
// on the origin row (register 0) and its left column on the origin column
// (register 1), with no clipping. Mark the first byte of each file with first.
// One byte is accepted every cycle while the four-entry pixel queue has room;
// a pixel passes through that queue and then the address stage's output register
// before it leaves the block. Write the origin only between files.
module bmp_to_framebuffer_writer_unit
   import bfw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_write_en,
   input  logic [0:0]         csr_index,
   input  logic [COORD_W-1:0] csr_wdata
);

   logic [COORD_W-1:0] origin_row_ff;
   logic [COORD_W-1:0] origin_col_ff;
   logic               take;
   logic               push;
   logic               pop;
   job_type            push_data;
   job_type            pop_data;
   queue_status_type   status;

   // Placement registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_row_ff <= '0;
         origin_col_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ORIGIN_ROW: origin_row_ff <= csr_wdata;
            CSR_ORIGIN_COL: origin_col_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input handshake: a byte is taken whenever the queue has room.
   assign req_ready = !status.full;
   assign take      = req_valid && req_ready;

   bfw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_data   (req_data),
      .origin_row (origin_row_ff),
      .origin_col (origin_col_ff),
      .push       (push),
      .push_data  (push_data)
   );

   bfw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   bfw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .job       (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/tb_bmp_to_framebuffer_writer_unit.sv]
module tb_bmp_to_framebuffer_writer_unit;
   import bfw_pkg::*;

   localparam int STALL_LIMIT       = 2000;
   localparam int HOLD_AT           = 20;
   localparam int HOLD_CYCLES       = 300;
   localparam int SETTLE_CYCLES     = 8;
   localparam int PHASE_ITEMS       = 30;
   localparam int MIN_RANDOM_PIXELS = 12;

   // Tracks the parser state of the block and keeps the framebuffer writes that
   // the accepted bytes must produce, oldest first.
   class pixel_scoreboard;
      logic [COORD_W-1:0]  origin_row;
      logic [COORD_W-1:0]  origin_col;
      logic [HCOUNT_W-1:0] header_count;
      logic [RAW_W-1:0]    raw_width;
      logic [RAW_W-1:0]    raw_height;
      logic [DIM_W-1:0]    img_width;
      logic [DIM_W-1:0]    img_height;
      logic [DIM_W-1:0]    column_count;
      logic [DIM_W-1:0]    file_row;
      phase_type           byte_phase;
      logic [1:0]          pad_left;
      logic [BYTE_W-1:0]   blue_hold;
      logic [BYTE_W-1:0]   green_hold;
      logic                in_pixels;
      rsp_type             pending_writes[$];
      int                  produced;
      int                  errors;

      function new();
         origin_row = '0;
         origin_col = '0;
         produced   = 0;
         errors     = 0;
         restart();
      endfunction

      function void restart();
         header_count = '0;
         raw_width    = '0;
         raw_height   = '0;
         img_width    = '0;
         img_height   = '0;
         column_count = '0;
         file_row     = '0;
         byte_phase   = PHASE_BLUE;
         pad_left     = '0;
         blue_hold    = '0;
         green_hold   = '0;
         in_pixels    = 1'b0;
      endfunction

      // A negative header dimension means an empty image; large ones saturate.
      function logic [DIM_W-1:0] saturate_dim(logic [RAW_W-1:0] raw);
         if (raw[RAW_W-1]) return '0;
         if (raw > RAW_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
         return raw[DIM_W-1:0];
      endfunction

      // Advances the parser by one accepted byte and queues the write it causes.
      function void note_byte(logic [BYTE_W-1:0] b, logic first);
         rsp_type     write;
         int unsigned fb_row;
         int unsigned fb_col;
         logic [63:0] linear;
         if (first) restart();

         // Header: collect the little-endian width and height.
         if (!in_pixels) begin
            if (header_count >= WIDTH_OFFSET && header_count < WIDTH_OFFSET + 4) begin
               raw_width |= RAW_W'(b) << (8 * (header_count - WIDTH_OFFSET));
            end else if (header_count >= HEIGHT_OFFSET && header_count < HEIGHT_OFFSET + 4) begin
               raw_height |= RAW_W'(b) << (8 * (header_count - HEIGHT_OFFSET));
            end
            header_count = header_count + 1'b1;
            if (header_count >= HEADER_BYTES) begin
               in_pixels  = 1'b1;
               img_width  = saturate_dim(raw_width);
               img_height = saturate_dim(raw_height);
            end
            return;
         end

         // Empty images and bytes past the last row are dropped.
         if (img_width == 0 || file_row >= img_height) return;
         if (pad_left != 0) begin
            pad_left = pad_left - 1'b1;
            return;
         end

         case (byte_phase)
            PHASE_BLUE: begin
               blue_hold  = b;
               byte_phase = PHASE_GREEN;
               return;
            end
            PHASE_GREEN: begin
               green_hold = b;
               byte_phase = PHASE_RED;
               return;
            end
            default: ;
         endcase

         // Red byte: the file is bottom-up, so file rows land in reverse order.
         fb_row = origin_row + img_height - 1 - file_row;
         fb_col = origin_col + column_count;
         linear = 64'(fb_row) * LINE_PIXELS + fb_col;
         write.fb_address = linear[ADDR_W-1:0];
         write.pixel      = {blue_hold, green_hold, b};
         write.last_pixel = (column_count + 1 == img_width) && (file_row + 1 == img_height);
         pending_writes.push_back(write);
         produced++;

         byte_phase   = PHASE_BLUE;
         column_count = column_count + 1'b1;
         if (column_count >= img_width) begin
            column_count = '0;
            file_row     = file_row + 1'b1;
            pad_left     = 2'((4 - ((3 * int'(img_width)) & 3)) & 3);
         end
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      // Compares one accepted write with the oldest one predicted.
      task check_pixel(rsp_type got);
         rsp_type want;
         if (pending_writes.size() == 0) begin
            report($sformatf("unexpected write addr=%0h pixel=%0h", got.fb_address, got.pixel));
            return;
         end
         want = pending_writes.pop_front();
         if (got.fb_address !== want.fb_address) begin
            report($sformatf("fb_address %0h, wanted %0h", got.fb_address, want.fb_address));
         end
         if (got.pixel !== want.pixel) begin
            report($sformatf("pixel %0h at %0h, wanted %0h", got.pixel, want.fb_address,
                             want.pixel));
         end
         if (got.last_pixel !== want.last_pixel) begin
            report($sformatf("last_pixel %0b at %0h, wanted %0b", got.last_pixel,
                             want.fb_address, want.last_pixel));
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_write_en;
   logic [0:0]         csr_index;
   logic [COORD_W-1:0] csr_wdata;

   pixel_scoreboard sb;
   bit              calm;
   bit              held;
   int              pixels_taken;
   int              quiet_cycles;
   int              file_items;

   bmp_to_framebuffer_writer_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int image_bytes(int w, int h);
      return h * (3 * w + ((4 - (3 * w) % 4) % 4));
   endfunction

   // Offers one byte, with an occasional gap first, and waits until it is taken.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first);
      req_type item;
      item.file_byte = b;
      item.first     = first;
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b, first);
   endtask

   // Sends a header with the given raw dimensions, then body and trailing bytes.
   // A fill of -1 gives random content, otherwise every data byte is the fill.
   task automatic send_file(input logic [RAW_W-1:0] w_raw, input logic [RAW_W-1:0] h_raw,
                            input bit mark, input int body_len, input int tail_len,
                            input int fill);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < HEADER_BYTES + body_len + tail_len; i++) begin
         b = 8'($urandom);
         if (i < HEADER_BYTES) begin
            if (i < 2 && $urandom_range(1) == 1) b = (i == 0) ? 8'h42 : 8'h4D;
            if (i >= WIDTH_OFFSET && i < WIDTH_OFFSET + 4) begin
               b = w_raw[8 * (i - WIDTH_OFFSET) +: 8];
            end else if (i >= HEIGHT_OFFSET && i < HEIGHT_OFFSET + 4) begin
               b = h_raw[8 * (i - HEIGHT_OFFSET) +: 8];
            end
         end else if (fill >= 0) begin
            b = 8'(fill);
         end
         send_byte(b, mark && i == 0);
         if (i < HEADER_BYTES + body_len) file_items++;
      end
   endtask

   // Stops offering bytes and lets every predicted write drain out.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Places the image origin; only done while the block is idle.
   task automatic set_origin(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
      settle();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ORIGIN_ROW;
      csr_wdata    <= row;
      @(posedge clock);
      csr_index    <= CSR_ORIGIN_COL;
      csr_wdata    <= col;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.origin_row = row;
      sb.origin_col = col;
   endtask

   // Result side: takes writes with random stalls and one long hold-off, so
   // that the pixel queue fills and the byte input stalls.
   initial begin : rsp_side
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_pixel(rsp_data);
            pixels_taken++;
         end
         if (pixels_taken == HOLD_AT && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= calm || $urandom_range(99) >= 7;
         end
      end
   end

   // Ends the run when neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[bmp_to_framebuffer_writer_unit] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int kind;
      int w;
      int h;
      int random_goal;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_ORIGIN_ROW;
      csr_wdata    = '0;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed files at the lowest origin. The first has no first mark, so
      // the bytes after reset must start a file; its trailing bytes are ignored.
      set_origin('0, '0);
      send_file(1, 1, 1'b0, image_bytes(1, 1), 3, 8'hFF);
      send_file(2, 2, 1'b1, image_bytes(2, 2), 0, 8'h00);
      // Negative width and zero height give empty images.
      send_file(32'h8000_0002, 1, 1'b1, 6, 0, -1);
      send_file(3, 0, 1'b1, 6, 0, -1);
      // Saturated width and height; the images are cut short by the next file.
      send_file(32'h0000_1000, 1, 1'b1, 12, 0, -1);
      send_file(1, 32'h7FFF_FFFF, 1'b1, 12, 0, -1);
      // A file broken off inside a pixel, then a complete one with padding.
      send_file(3, 2, 1'b1, 5, 0, -1);
      send_file(5, 3, 1'b1, image_bytes(5, 3), 2, -1);

      // Highest origin: the largest origin row and column the registers can hold.
      set_origin(11'h7FF, 11'h7FF);
      send_file(4, 3, 1'b1, image_bytes(4, 3), 0, 8'hFF);
      send_file(1, 5000, 1'b1, 12, 0, -1);
      send_file(MAX_DIM, 1, 1'b1, 9, 0, -1);

      // Random files under several origins; the second phase runs without idling.
      random_goal = sb.produced + MIN_RANDOM_PIXELS;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_origin('0, 11'h7FF);
            1: set_origin(11'h7FF, '0);
            default: set_origin(11'($urandom), 11'($urandom));
         endcase
         calm       = (ph == 1);
         file_items = 0;
         while (file_items < PHASE_ITEMS || (ph == 3 && sb.produced < random_goal)) begin
            kind = $urandom_range(99);
            w    = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            h    = $urandom_range(1, 4);
            if (kind < 70) begin
               // Mostly well-formed small images, now and then empty or unmarked.
               if ($urandom_range(11) == 0) w = 0;
               if ($urandom_range(11) == 0) h = 0;
               send_file(w, h, $urandom_range(19) != 0, image_bytes(w, h),
                         ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0, -1);
            end else if (kind < 80) begin
               // Arbitrary raw dimensions, mostly negative or saturated.
               send_file($urandom, $urandom, 1'b1, $urandom_range(0, 30), 0, -1);
            end else if (kind < 90) begin
               // An image cut short anywhere in its body.
               send_file(w, h, 1'b1, $urandom_range(0, image_bytes(w, h) - 1), 0, -1);
            end else begin
               // Loose bytes, some of them marking a new file.
               repeat ($urandom_range(1, 20)) begin
                  send_byte(8'($urandom), $urandom_range(9) == 0);
               end
            end
         end
      end
      calm = 1'b0;

      settle();
      if (sb.errors == 0) begin
         $display("[bmp_to_framebuffer_writer_unit] OK");
      end else begin
         $display("[bmp_to_framebuffer_writer_unit] ERROR");
      end
      $finish;
   end

endmodule
